// ----- rtl/zobtt_pkg.sv -----
// ----------------------------------------------------------------------------
// Zobrist transposition table package
// Shared constants, operation codes and the queued item type.
// ----------------------------------------------------------------------------
package zobtt_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int BOARD_SIDE  = 10;
  localparam int PIECE_KINDS = 4;
  localparam int KEY_WORDS   = PIECE_KINDS * BOARD_SIDE * BOARD_SIDE;
  localparam int SLOT_W      = $clog2(KEY_WORDS);
  localparam int TBL_DEPTH   = 1 << INDEX_BITS;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_TOGGLE = 3'd2;
  localparam logic [2:0] OP_MOVE   = 3'd3;
  localparam logic [2:0] OP_PROBE  = 3'd4;
  localparam logic [2:0] OP_STORE  = 3'd5;

  localparam logic [1:0] BND_EXACT = 2'd0;
  localparam logic [1:0] BND_LOWER = 2'd1;
  localparam logic [1:0] BND_UPPER = 2'd2;

  localparam logic [1:0] REG_WHITE_MAN  = 2'd0;
  localparam logic [1:0] REG_BLACK_MAN  = 2'd1;
  localparam logic [1:0] REG_WHITE_KING = 2'd2;
  localparam logic [1:0] REG_BLACK_KING = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic              a_ok;
    logic [SLOT_W-1:0] slot_a;
    logic              b_ok;
    logic [SLOT_W-1:0] slot_b;
    logic [31:0]       skey;
    logic [63:0]       lkey;
    logic [31:0]       sa;
    logic [31:0]       beta;
    logic [7:0]        depth;
    logic [1:0]        bound;
  } item_t;

endpackage

// ----- rtl/zobrist_transposition_table.sv -----
// ----------------------------------------------------------------------------
// Zobrist transposition table
// Running Zobrist keys with a direct-mapped, depth-preferred hash table.
// ----------------------------------------------------------------------------
//  channel   signals                               handshake
//  command   operation .. bound_type               start & !busy
//  result    hit, score, key_short_now/long_now    done, one cycle
//  config    cfg_we, cfg_index, cfg_data           cfg_we
//
//  Load, clear and unused codes finish from idle; toggle runs S_KEY_A,
//  probe and store S_TBL, move S_KEY_A then S_KEY_B; the key memory and table
//  read ports are registered. After reset a clearing pass over all 4096 entries
//  empties the table; busy is high. A two-beat queue sits between front and
//  back; busy rises when it is full. Results cannot be held off.
// ----------------------------------------------------------------------------
module zobrist_transposition_table import zobtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [2:0]  kind,
  input  logic [3:0]  from_x,
  input  logic [3:0]  from_y,
  input  logic [3:0]  to_x,
  input  logic [3:0]  to_y,
  input  logic [31:0] short_key,
  input  logic [63:0] long_key,
  input  logic [31:0] score_or_alpha,
  input  logic [31:0] beta_bound,
  input  logic [7:0]  search_depth,
  input  logic [1:0]  bound_type,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  output logic        done,
  output logic        hit,
  output logic [31:0] score,
  output logic [31:0] key_short_now,
  output logic [63:0] key_long_now
);

  logic  q_valid, q_full, pop, clearing;
  item_t q_head;

  assign busy = q_full || clearing;

  zobtt_front u_front (
    .clk, .rst,
    .accept(start && !busy),
    .operation, .kind, .from_x, .from_y, .to_x, .to_y,
    .short_key, .long_key, .score_or_alpha, .beta_bound,
    .search_depth, .bound_type,
    .cfg_we, .cfg_index, .cfg_data,
    .pop, .q_valid, .q_full, .q_head
  );

  zobtt_back u_back (
    .clk, .rst, .q_valid, .q_head, .pop, .clearing,
    .done, .hit, .score, .key_short_now, .key_long_now
  );

endmodule

// ----- rtl/zobtt_front.sv -----
// ----------------------------------------------------------------------------
// Zobrist transposition table front end
// Accepts commands, resolves key slots and promotion, queues decoded items.
// ----------------------------------------------------------------------------
module zobtt_front import zobtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  operation,
  input  logic [2:0]  kind,
  input  logic [3:0]  from_x,
  input  logic [3:0]  from_y,
  input  logic [3:0]  to_x,
  input  logic [3:0]  to_y,
  input  logic [31:0] short_key,
  input  logic [63:0] long_key,
  input  logic [31:0] score_or_alpha,
  input  logic [31:0] beta_bound,
  input  logic [7:0]  search_depth,
  input  logic [1:0]  bound_type,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        pop,
  output logic        q_valid,
  output logic        q_full,
  output item_t       q_head
);

  logic [2:0] white_man, black_man, white_king, black_king;
  item_t      fifo [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  item_t      dec;
  logic [2:0] dest;

  function automatic logic slot_ok(logic [2:0] k, logic [3:0] x, logic [3:0] y);
    return (k >= 3'd1) && (32'(k) <= PIECE_KINDS) &&
           (32'(x) < BOARD_SIDE) && (32'(y) < BOARD_SIDE);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(logic [2:0] k, logic [3:0] x,
                                                  logic [3:0] y);
    int s;
    s = ((int'(k) - 1) * BOARD_SIDE + int'(x)) * BOARD_SIDE + int'(y);
    return SLOT_W'(s);
  endfunction

  always_comb begin
    dest = kind;
    if (to_y == 4'd0 && kind == white_man) dest = white_king;
    if (32'(to_y) == BOARD_SIDE - 1 && kind == black_man) dest = black_king;
    dec.op     = operation;
    dec.a_ok   = slot_ok(kind, from_x, from_y);
    dec.slot_a = slot_of(kind, from_x, from_y);
    dec.b_ok   = slot_ok(dest, to_x, to_y);
    dec.slot_b = slot_of(dest, to_x, to_y);
    dec.skey   = short_key;
    dec.lkey   = long_key;
    dec.sa     = score_or_alpha;
    dec.beta   = beta_bound;
    dec.depth  = search_depth;
    dec.bound  = bound_type;
  end

  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);
  assign q_head  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) fifo[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      count      <= 2'd0;
      white_man  <= 3'd1;
      black_man  <= 3'd2;
      white_king <= 3'd3;
      black_king <= 3'd4;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, pop};
      if (cfg_we) begin
        case (cfg_index)
          REG_WHITE_MAN:  white_man  <= cfg_data;
          REG_BLACK_MAN:  black_man  <= cfg_data;
          REG_WHITE_KING: white_king <= cfg_data;
          REG_BLACK_KING: black_king <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !accept || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");

endmodule

// ----- rtl/zobtt_back.sv -----
// ----------------------------------------------------------------------------
// Zobrist transposition table back end
// Runs queued items against the key memories, running keys and hash table.
// ----------------------------------------------------------------------------
module zobtt_back import zobtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_head,
  output logic        pop,
  output logic        clearing,
  output logic        done,
  output logic        hit,
  output logic [31:0] score,
  output logic [31:0] key_short_now,
  output logic [63:0] key_long_now
);

  typedef enum logic [2:0] {S_IDLE, S_KEY_A, S_KEY_B, S_TBL} state_t;

  state_t                state;
  item_t                 cur;
  logic [INDEX_BITS-1:0] clr_addr;
  logic [INDEX_BITS-1:0] idx;
  logic [31:0]           run_s;
  logic [63:0]           run_l;

  logic [31:0]       skey_mem [KEY_WORDS];
  logic [63:0]       lkey_mem [KEY_WORDS];
  logic [SLOT_W-1:0] key_raddr;
  logic [31:0]       kd_s;
  logic [63:0]       kd_l;

  logic [63:0] chk_mem [TBL_DEPTH];
  logic [31:0] scr_mem [TBL_DEPTH];
  logic [7:0]  dep_mem [TBL_DEPTH];
  logic [1:0]  bnd_mem [TBL_DEPTH];
  logic        vld_mem [TBL_DEPTH];
  logic [63:0] e_chk;
  logic [31:0] e_scr;
  logic [7:0]  e_dep;
  logic [1:0]  e_bnd;
  logic        e_vld;

  logic key_we, tbl_we, vld_we, vld_wd;
  logic [INDEX_BITS-1:0] vld_waddr;
  logic usable, ok;

  assign pop       = (state == S_IDLE) && q_valid && !clearing;
  assign key_raddr = (state == S_IDLE) ? q_head.slot_a : cur.slot_b;
  assign key_we    = pop && q_head.op == OP_LOAD && q_head.a_ok;
  assign tbl_we    = (state == S_TBL) && cur.op == OP_STORE && (!e_vld || e_dep < cur.depth);
  assign vld_we    = clearing || tbl_we;
  assign vld_wd    = !clearing;
  assign vld_waddr = clearing ? clr_addr : idx;
  assign key_short_now = run_s;
  assign key_long_now  = run_l;

  always_comb begin
    usable = e_vld && e_chk == run_l && e_dep >= cur.depth;
    case (e_bnd)
      BND_EXACT: ok = 1'b1;
      BND_LOWER: ok = $signed(e_scr) >= $signed(cur.beta);
      BND_UPPER: ok = $signed(cur.sa) >= $signed(e_scr);
      default:   ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      skey_mem[q_head.slot_a] <= q_head.skey;
      lkey_mem[q_head.slot_a] <= q_head.lkey;
    end
    kd_s <= skey_mem[key_raddr];
    kd_l <= lkey_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      chk_mem[idx] <= run_l;
      scr_mem[idx] <= cur.sa;
      dep_mem[idx] <= cur.depth;
      bnd_mem[idx] <= cur.bound;
    end
    if (vld_we) vld_mem[vld_waddr] <= vld_wd;
    e_chk <= chk_mem[run_s[INDEX_BITS-1:0]];
    e_scr <= scr_mem[run_s[INDEX_BITS-1:0]];
    e_dep <= dep_mem[run_s[INDEX_BITS-1:0]];
    e_bnd <= bnd_mem[run_s[INDEX_BITS-1:0]];
    e_vld <= vld_mem[run_s[INDEX_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      clearing <= 1'b1;
      clr_addr <= '0;
      run_s    <= '0;
      run_l    <= '0;
      done     <= 1'b0;
      hit      <= 1'b0;
      score    <= '0;
    end else begin
      done <= 1'b0;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) clearing <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur   <= q_head;
            idx   <= run_s[INDEX_BITS-1:0];
            hit   <= 1'b0;
            score <= '0;
            case (q_head.op)
              OP_TOGGLE, OP_MOVE: state <= S_KEY_A;
              OP_PROBE, OP_STORE: state <= S_TBL;
              OP_CLEAR: begin
                run_s <= '0;
                run_l <= '0;
                done  <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_KEY_A: begin
          if (cur.a_ok) begin
            run_s <= run_s ^ kd_s;
            run_l <= run_l ^ kd_l;
          end
          if (cur.op == OP_MOVE) begin
            state <= S_KEY_B;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_KEY_B: begin
          if (cur.b_ok) begin
            run_s <= run_s ^ kd_s;
            run_l <= run_l ^ kd_l;
          end
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_TBL: begin
          if (cur.op == OP_PROBE && usable && ok) begin
            hit   <= 1'b1;
            score <= e_scr;
          end
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_while_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> state == S_IDLE && !pop) else $error("work during clear");
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE || $past(pop)) else $error("stray done");
  a_hit_probe_only: assert property (@(posedge clk) disable iff (rst)
    hit |-> cur.op == OP_PROBE) else $error("hit outside probe");

endmodule
